[rtl/lag_pkg.sv]
`timescale 1ns / 1ps

package lag_pkg;

    localparam int GRID_ROWS_W = 12;
    localparam int GRID_COLS_W = 6;
    localparam int CFG_DATA_W  = 12;
    localparam int CELL_W      = 2;

    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 12'd32;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 6'd32;

    // register indexes on the configuration port
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL  = 2'd1;

    // live bits one column shows to its neighbors
    typedef struct packed {
        logic above;
        logic current;
        logic incoming;
    } live_t;

    // controls broadcast to every column
    typedef struct packed {
        logic shift;
        logic have_above;
        logic have_below;
    } cell_ctl_t;

endpackage

[rtl/life_automaton_generation_core.sv]
`timescale 1ns / 1ps

// Streaming B3/S23 Life generator over a grid sent in raster order, one cell per
// beat. Each column is a small cell holding three rows (above, current, incoming)
// that trades live bits with its two neighbors; results come out one row plus one
// cell behind the input, through a single output register. Inside a row one input
// beat is taken every clock while the output register can load. Past the first row,
// the beat that ends a row yields two results; the beat that ends a frame also
// flushes the last row, one result per column, and takes no input before the last
// flush step. One result leaves per clock at most.
module life_automaton_generation_core #(
    parameter int MAX_COLS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_addr,
    input  logic [lag_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lag_pkg::CELL_W-1:0]           s_cell_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lag_pkg::CELL_W-1:0]           m_cell_out,
    output logic                                 m_run_last,
    output logic                                 m_frame_end
);

    localparam int CW = $clog2(MAX_COLS);
    localparam logic [lag_pkg::GRID_COLS_W-1:0] MAXC = lag_pkg::GRID_COLS_W'(MAX_COLS);

    // configuration
    logic [lag_pkg::GRID_ROWS_W-1:0] grid_rows_reg;
    logic [lag_pkg::GRID_COLS_W-1:0] grid_cols_reg;
    logic [lag_pkg::GRID_ROWS_W-1:0] rows_m1;
    logic [lag_pkg::GRID_COLS_W-1:0] cols;
    logic [lag_pkg::GRID_COLS_W-1:0] cols_m1;

    // raster position
    logic [lag_pkg::GRID_ROWS_W-1:0] row_reg;
    logic [CW-1:0]                   col_reg;
    logic [lag_pkg::GRID_ROWS_W-1:0] r_used;
    logic [lag_pkg::GRID_COLS_W-1:0] c_used;
    logic [CW-1:0]                   c_idx;
    logic                            row_end;
    logic                            frame_last;
    logic                            accept;

    // pending work of the last accepted beat
    logic          job_a_reg, job_a_next;
    logic          job_b_reg, job_b_next;
    logic          job_shift_reg, job_shift_next;
    logic          job_flush_reg, job_flush_next;
    logic          job_above_reg;
    logic [CW-1:0] idx_a_reg;
    logic [CW-1:0] flush_cnt_reg, flush_cnt_next;
    logic          job_valid;
    logic          do_a, do_b, do_shift, do_flush, do_emit;
    logic          flush_done;
    logic          job_last_step;
    logic          out_can_load;
    logic          step_go;

    // output register
    logic                        m_valid_reg;
    logic [lag_pkg::CELL_W-1:0]  m_cell_out_reg;
    logic                        m_run_last_reg;
    logic                        m_frame_end_reg;

    // column row
    lag_pkg::cell_ctl_t         ctl;
    lag_pkg::live_t             live_w [MAX_COLS];
    logic [lag_pkg::CELL_W-1:0] next_w [MAX_COLS];
    logic [CW-1:0]              sel_idx;
    logic [lag_pkg::CELL_W-1:0] sel_cell;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= lag_pkg::GRID_ROWS_RESET;
            grid_cols_reg <= lag_pkg::GRID_COLS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lag_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                lag_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata[lag_pkg::GRID_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to their legal range
    always_comb begin
        if (grid_cols_reg < 6'd2) begin
            cols = 6'd2;
        end else if (grid_cols_reg > MAXC) begin
            cols = MAXC;
        end else begin
            cols = grid_cols_reg;
        end
        cols_m1 = cols - 6'd1;
        rows_m1 = (grid_rows_reg < 12'd2) ? 12'd1 : (grid_rows_reg - 12'd1);
    end

    // position clamped to the current size
    assign c_used     = (lag_pkg::GRID_COLS_W'(col_reg) > cols_m1) ? cols_m1
                                                                  : lag_pkg::GRID_COLS_W'(col_reg);
    assign r_used     = (row_reg > rows_m1) ? rows_m1 : row_reg;
    assign c_idx      = c_used[CW-1:0];
    assign row_end    = (c_used == cols_m1);
    assign frame_last = row_end && (r_used == rows_m1);
    assign accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_last ? '0 : (r_used + 12'd1);
            end else begin
                col_reg <= c_idx + CW'(1);
                row_reg <= r_used;
            end
        end
    end

    // step order: left neighbor result, row end result with row hand-over, flush
    assign job_valid     = job_a_reg || job_b_reg || job_shift_reg || job_flush_reg;
    assign do_a          = job_a_reg;
    assign do_b          = !job_a_reg && job_b_reg;
    assign do_shift      = !job_a_reg && job_shift_reg;
    assign do_flush      = !job_a_reg && !job_b_reg && !job_shift_reg && job_flush_reg;
    assign do_emit       = do_a || do_b || do_flush;
    assign flush_done    = (flush_cnt_reg == cols_m1[CW-1:0]);
    assign job_last_step = (do_a && !job_b_reg && !job_shift_reg)
                         || (do_shift && !job_flush_reg)
                         || (do_flush && flush_done);
    assign out_can_load  = !m_valid_reg || m_ready;
    assign step_go       = job_valid && (!do_emit || out_can_load);
    assign s_ready       = !job_valid || (step_go && job_last_step);

    always_comb begin
        job_a_next     = job_a_reg;
        job_b_next     = job_b_reg;
        job_shift_next = job_shift_reg;
        job_flush_next = job_flush_reg;
        flush_cnt_next = flush_cnt_reg;
        if (step_go) begin
            if (do_a) begin
                job_a_next = 1'b0;
            end
            if (do_b) begin
                job_b_next = 1'b0;
            end
            if (do_shift) begin
                job_shift_next = 1'b0;
            end
            if (do_flush) begin
                flush_cnt_next = flush_cnt_reg + CW'(1);
                if (flush_done) begin
                    job_flush_next = 1'b0;
                end
            end
        end
        if (accept) begin
            job_a_next     = (r_used != 12'd0) && (c_used != 6'd0);
            job_b_next     = (r_used != 12'd0) && row_end;
            job_shift_next = row_end;
            job_flush_next = frame_last;
            flush_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_a_reg     <= 1'b0;
            job_b_reg     <= 1'b0;
            job_shift_reg <= 1'b0;
            job_flush_reg <= 1'b0;
            flush_cnt_reg <= '0;
        end else begin
            job_a_reg     <= job_a_next;
            job_b_reg     <= job_b_next;
            job_shift_reg <= job_shift_next;
            job_flush_reg <= job_flush_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_above_reg <= (r_used >= 12'd2);
            idx_a_reg     <= c_idx - CW'(1);
        end
    end

    assign ctl.shift      = step_go && do_shift;
    assign ctl.have_above = do_flush ? 1'b1 : job_above_reg;
    assign ctl.have_below = !do_flush;

    genvar x;
    generate
        for (x = 0; x < MAX_COLS; x++) begin : g_col
            lag_pkg::live_t left_live;
            lag_pkg::live_t right_live;
            logic           in_range;

            if (x == 0) begin : g_first
                assign left_live = '0;
            end else begin : g_mid_l
                assign left_live = live_w[x-1];
            end
            if (x == MAX_COLS - 1) begin : g_last
                assign right_live = '0;
            end else begin : g_mid_r
                assign right_live = live_w[x+1];
            end
            assign in_range = (7'(x) < 7'(cols));

            lag_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .wr_en      (accept && (c_idx == CW'(x))),
                .wr_cell    (s_cell_in),
                .ctl        (ctl),
                .in_range   (in_range),
                .left_live  (left_live),
                .right_live (right_live),
                .live       (live_w[x]),
                .next_cell  (next_w[x])
            );
        end
    endgenerate

    always_comb begin
        if (do_a) begin
            sel_idx = idx_a_reg;
        end else if (do_b) begin
            sel_idx = cols_m1[CW-1:0];
        end else begin
            sel_idx = flush_cnt_reg;
        end
    end
    assign sel_cell = next_w[sel_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_go && do_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go && do_emit) begin
            m_cell_out_reg  <= sel_cell;
            m_run_last_reg  <= job_last_step;
            m_frame_end_reg <= do_flush && flush_done;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cell_out  = m_cell_out_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_frame_end = m_frame_end_reg;

`ifndef SYNTHESIS
    // row end result always comes with the row hand-over
    a_b_with_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        job_b_reg |-> job_shift_reg)
        else $error("row end result pending without row hand-over");

    // flush runs only after the row results are out
    a_flush_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_flush_reg && !job_shift_reg) |-> (!job_a_reg && !job_b_reg))
        else $error("flush overlaps row results");

    // a result step always lands in the output register
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_go && do_emit) |=> m_valid_reg)
        else $error("result step lost");

    // the frame's final cell closes its beat's run
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_frame_end_reg) |-> m_run_last_reg)
        else $error("frame end without run last");

    // no input is taken before the last flush step of the last row
    a_no_accept_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_flush && !flush_done) |-> !s_ready)
        else $error("input taken during flush");
`endif

endmodule

[rtl/lag_cell.sv]
`timescale 1ns / 1ps

module lag_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [lag_pkg::CELL_W-1:0]   wr_cell,
    input  lag_pkg::cell_ctl_t           ctl,
    input  logic                         in_range,
    input  lag_pkg::live_t               left_live,
    input  lag_pkg::live_t               right_live,
    output lag_pkg::live_t               live,
    output logic [lag_pkg::CELL_W-1:0]   next_cell
);

    logic [lag_pkg::CELL_W-1:0] above_reg;
    logic [lag_pkg::CELL_W-1:0] current_reg;
    logic [lag_pkg::CELL_W-1:0] incoming_reg;
    logic [3:0]                 count;
    logic                       ha;
    logic                       hb;
    logic                       self_above;
    logic                       self_incoming;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg    <= lag_pkg::CELL_EMPTY;
            current_reg  <= lag_pkg::CELL_EMPTY;
            incoming_reg <= lag_pkg::CELL_EMPTY;
        end else begin
            // row hand-over: the incoming row keeps its contents
            if (ctl.shift) begin
                above_reg   <= current_reg;
                current_reg <= incoming_reg;
            end
            if (wr_en) begin
                incoming_reg <= wr_cell;
            end
        end
    end

    assign live.above    = in_range && (above_reg == lag_pkg::CELL_WALL);
    assign live.current  = in_range && (current_reg == lag_pkg::CELL_WALL);
    assign live.incoming = in_range && (incoming_reg == lag_pkg::CELL_WALL);

    assign ha            = ctl.have_above;
    assign hb            = ctl.have_below;
    assign self_above    = live.above;
    assign self_incoming = live.incoming;

    assign count = 4'(left_live.above & ha) + 4'(self_above & ha) + 4'(right_live.above & ha)
                 + 4'(left_live.incoming & hb) + 4'(self_incoming & hb)
                 + 4'(right_live.incoming & hb)
                 + 4'(left_live.current) + 4'(right_live.current);

    always_comb begin
        case (current_reg)
            lag_pkg::CELL_WALL:
                next_cell = (count == 4'd2 || count == 4'd3) ? lag_pkg::CELL_WALL
                                                             : lag_pkg::CELL_EMPTY;
            lag_pkg::CELL_EMPTY:
                next_cell = (count == 4'd3) ? lag_pkg::CELL_WALL : lag_pkg::CELL_EMPTY;
            default:
                next_cell = current_reg;  // markers and unused code pass through
        endcase
    end

endmodule
